/* hw/rtl/fssc_pkg.sv */
// Package for the floppy soft-switch controller.
// Holds item layouts, switch and event codes, register indexes, reset values
// and the stepper delta table. No dependencies.
package fssc_pkg;

  // Field widths
  localparam int unsigned PhaseW    = 2;
  localparam int unsigned PosW      = 8;
  localparam int unsigned TimerW    = 24;
  localparam int unsigned TickW     = 16;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned CfgIndexW = 2;
  localparam int unsigned CfgDataW  = 24;
  localparam int unsigned InDataW   = 40;
  localparam int unsigned OutDataW  = 40;

  // Request kind (travels in tuser)
  typedef enum logic [1:0] {
    KIND_READ  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_TICK  = 2'd2,
    KIND_NONE  = 2'd3
  } kind_e;

  // Soft switches come in pairs; offset[3:1] names the pair, offset[0] picks off/on
  typedef enum logic [2:0] {
    GRP_PHASE0 = 3'd0,
    GRP_PHASE1 = 3'd1,
    GRP_PHASE2 = 3'd2,
    GRP_PHASE3 = 3'd3,
    GRP_MOTOR  = 3'd4,
    GRP_DRIVE  = 3'd5,
    GRP_Q6     = 3'd6,
    GRP_Q7     = 3'd7
  } sw_grp_e;

  typedef enum logic [1:0] {
    HEV_NONE = 2'd0,
    HEV_STEP = 2'd1,
    HEV_BUMP = 2'd2
  } head_event_e;

  typedef enum logic [2:0] {
    MEV_NONE      = 3'd0,
    MEV_OFF       = 3'd1,
    MEV_ON        = 3'd2,
    MEV_ON_ENGAGE = 3'd3,
    MEV_DISENGAGE = 3'd4
  } motor_event_e;

  typedef enum logic [CfgIndexW-1:0] {
    CFG_SPINDOWN = 2'd0,
    CFG_SPINUP   = 2'd1,
    CFG_MAX_QT   = 2'd2,
    CFG_IWM_EN   = 2'd3
  } cfg_idx_e;

  // Register reset values
  localparam logic [TimerW-1:0] SpindownReset = 24'd1023000;
  localparam logic [TimerW-1:0] SpinupReset   = 24'd71610;
  localparam logic [PosW-1:0]   MaxQtReset    = 8'd159;

  // Read data constants
  localparam logic [ByteW-1:0] SyncByte    = 8'h80;
  localparam logic [ByteW-1:0] WpBit       = 8'h80;
  localparam logic [ByteW-1:0] MotorBit    = 8'h20;
  localparam logic [ByteW-1:0] ModeMask    = 8'h1F;

  // Input item, lowest field in the lowest bits
  typedef struct packed {
    logic [2:0]       pad;
    logic             write_protected;
    logic [ByteW-1:0] engine_latch;
    logic [TickW-1:0] tick_cycles;
    logic [ByteW-1:0] write_value;
    logic [3:0]       switch_offset;
  } in_item_t;

  // Result item, lowest field in the lowest bits
  typedef struct packed {
    logic [4:0]       pad;
    logic             write_mode;
    logic             shift_load_mode;
    logic             drive_select_event;
    logic             selected_drive;
    motor_event_e     motor_event;
    logic             motor_running;
    head_event_e      head_event;
    logic [PosW-1:0]  head_position;
    logic [ByteW-1:0] latch_byte;
    logic             latch_load;
    logic [ByteW-1:0] read_data;
  } out_item_t;

  // Head stepper request and response
  typedef struct packed {
    logic              en;
    logic [PhaseW-1:0] phase;
    logic              on;
  } head_req_t;

  typedef struct packed {
    logic [PosW-1:0] pos;
    head_event_e     ev;
  } head_rsp_t;

  // Quarter-track delta for energizing phase ph after last phase lp (table times two)
  function automatic logic signed [3:0] step_delta(logic [PhaseW-1:0] lp,
                                                   logic [PhaseW-1:0] ph);
    logic signed [3:0] d;
    unique case ({lp, ph})
      4'b00_00: d = 4'sd0;
      4'b00_01: d = 4'sd2;
      4'b00_10: d = 4'sd4;
      4'b00_11: d = -4'sd2;
      4'b01_00: d = -4'sd2;
      4'b01_01: d = 4'sd0;
      4'b01_10: d = 4'sd2;
      4'b01_11: d = 4'sd4;
      4'b10_00: d = -4'sd4;
      4'b10_01: d = -4'sd2;
      4'b10_10: d = 4'sd0;
      4'b10_11: d = 4'sd2;
      4'b11_00: d = 4'sd2;
      4'b11_01: d = -4'sd4;
      4'b11_10: d = -4'sd2;
      default:  d = 4'sd0;
    endcase
    return d;
  endfunction

endpackage

/* hw/rtl/fssc_head.sv */
// Head stepper: last energized phase, head quarter-track and the step/bump logic.
// Depends on fssc_pkg.
module fssc_head (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  fssc_pkg::head_req_t      req_i,
  input  logic [fssc_pkg::PosW-1:0] max_qt_i,
  output fssc_pkg::head_rsp_t      rsp_o
);
  import fssc_pkg::*;

  logic [PhaseW-1:0] last_phase_q, last_phase_d;
  logic [PosW-1:0]   head_q;

  logic signed [3:0]      delta;
  logic signed [PosW+1:0] raw;
  logic signed [PosW+1:0] max_s;
  logic                   below, above;

  // Target position and clamp
  always_comb begin
    delta        = req_i.on ? step_delta(last_phase_q, req_i.phase) : 4'sd0;
    last_phase_d = req_i.on ? req_i.phase : last_phase_q;
    raw          = $signed({2'b00, head_q}) + (PosW+2)'(delta);
    max_s        = $signed({2'b00, max_qt_i});
    below        = raw[PosW+1];
    above        = raw > max_s;

    rsp_o.pos = head_q;
    rsp_o.ev  = HEV_NONE;
    if (req_i.en) begin
      if (below) begin
        rsp_o.pos = '0;
      end else if (above) begin
        rsp_o.pos = max_qt_i;
      end else begin
        rsp_o.pos = raw[PosW-1:0];
      end
      if (delta != 4'sd0) begin
        rsp_o.ev = (below || above) ? HEV_BUMP : HEV_STEP;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_phase_q <= '0;
      head_q       <= '0;
    end else if (req_i.en) begin
      last_phase_q <= last_phase_d;
      head_q       <= rsp_o.pos;
    end
  end

endmodule

/* hw/rtl/floppy_stepper_motor_switch_ctrl.sv */
// Soft-switch controller of a 5.25-inch floppy card: phases, motor timers, drive
// select, Q6/Q7 latches and the read/write byte paths. Uses fssc_pkg and fssc_head.
//
// Each request (bus read, bus write or tick) gives exactly one result. The block
// takes one request per cycle unless the result stream stalls: a request is captured in
// an input register, decoded against the controller state, and its result lands in the
// output register, from which it is offered. The state update and the result are
// written at the same edge, so the next request already sees it. Configuration writes
// are always accepted and should only be issued while no request is in flight.
module floppy_stepper_motor_switch_ctrl (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Request stream
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // tdata: switch_offset[3:0], write_value[11:4], tick_cycles[27:12],
  //        engine_latch[35:28], write_protected[36], zero pad[39:37]
  input  logic [fssc_pkg::InDataW-1:0]       s_axis_tdata,
  // tuser: kind[1:0]
  input  logic [1:0]                         s_axis_tuser,
  // Result stream
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // tdata: read_data[7:0], latch_load[8], latch_byte[16:9], head_position[24:17],
  //        head_event[26:25], motor_running[27], motor_event[30:28],
  //        selected_drive[31], drive_select_event[32], shift_load_mode[33],
  //        write_mode[34], zero pad[39:35]
  output logic [fssc_pkg::OutDataW-1:0]      m_axis_tdata,
  // Configuration write channel
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [fssc_pkg::CfgIndexW-1:0]     cfg_index_i,
  input  logic [fssc_pkg::CfgDataW-1:0]      cfg_data_i
);
  import fssc_pkg::*;

  // Configuration registers
  logic [TimerW-1:0] spindown_cfg_q, spinup_cfg_q;
  logic [PosW-1:0]   max_qt_q;
  logic              iwm_en_q;

  // Pipeline registers
  logic      in_valid_q, out_valid_q;
  in_item_t  in_q;
  kind_e     kind_q;
  out_item_t out_q, out_d;
  logic      out_free, process;

  // Controller state
  logic              motor_q, motor_d;
  logic [TimerW-1:0] spindown_q, spindown_d;
  logic [TimerW-1:0] spinup_q, spinup_d;
  logic              drive_q, drive_d;
  logic              q6_q, q6_d;
  logic              q7_q, q7_d;
  logic [ByteW-1:0]  mode_q, mode_d;

  head_req_t head_req;
  head_rsp_t head_rsp;

  // Handshakes
  assign cfg_ready_o   = 1'b1;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign process       = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spindown_cfg_q <= SpindownReset;
      spinup_cfg_q   <= SpinupReset;
      max_qt_q       <= MaxQtReset;
      iwm_en_q       <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_SPINDOWN: spindown_cfg_q <= cfg_data_i;
        CFG_SPINUP:   spinup_cfg_q   <= cfg_data_i;
        CFG_MAX_QT:   max_qt_q       <= cfg_data_i[PosW-1:0];
        CFG_IWM_EN:   iwm_en_q       <= cfg_data_i[0];
        default:      ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_q   <= in_item_t'(s_axis_tdata);
      kind_q <= kind_e'(s_axis_tuser);
    end
  end

  // Head stepper request: phase switches on bus accesses
  always_comb begin
    head_req.en    = process && (kind_q == KIND_READ || kind_q == KIND_WRITE)
                     && !in_q.switch_offset[3];
    head_req.phase = in_q.switch_offset[2:1];
    head_req.on    = in_q.switch_offset[0];
  end

  fssc_head u_head (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (head_req),
    .max_qt_i (max_qt_q),
    .rsp_o    (head_rsp)
  );

  // Switch decode, timers and byte paths
  always_comb begin
    logic [TimerW-1:0] cyc;
    logic              access;
    motor_d    = motor_q;
    spindown_d = spindown_q;
    spinup_d   = spinup_q;
    drive_d    = drive_q;
    q6_d       = q6_q;
    q7_d       = q7_q;
    mode_d     = mode_q;
    cyc        = TimerW'(in_q.tick_cycles);
    access     = 1'b0;

    out_d                    = '0;

    unique case (kind_q)
      KIND_READ, KIND_WRITE: begin
        access = 1'b1;
        unique case (sw_grp_e'(in_q.switch_offset[3:1]))
          GRP_MOTOR: begin
            if (!in_q.switch_offset[0]) begin
              if (motor_q && spindown_q == '0) begin
                spindown_d = (spindown_cfg_q != '0) ? spindown_cfg_q : TimerW'(1);
              end
              out_d.motor_event = MEV_OFF;
            end else begin
              spindown_d = '0;
              motor_d    = 1'b1;
              if (!motor_q) begin
                spinup_d          = spinup_cfg_q;
                out_d.motor_event = MEV_ON_ENGAGE;
              end else begin
                out_d.motor_event = MEV_ON;
              end
            end
          end
          GRP_DRIVE: begin
            drive_d                  = in_q.switch_offset[0];
            out_d.drive_select_event = 1'b1;
          end
          GRP_Q6: q6_d = in_q.switch_offset[0];
          GRP_Q7: q7_d = in_q.switch_offset[0];
          default: ; // phase switches are handled by the head stepper
        endcase
      end
      KIND_TICK: begin
        // Saturating countdowns
        spinup_d = (cyc >= spinup_q) ? '0 : spinup_q - cyc;
        if (spindown_q != '0) begin
          if (cyc >= spindown_q) begin
            spindown_d        = '0;
            motor_d           = 1'b0;
            out_d.motor_event = MEV_DISENGAGE;
          end else begin
            spindown_d = spindown_q - cyc;
          end
        end
      end
      default: ;
    endcase

    // Bus read data and write latch, seen with the updated latches
    if (access && kind_q == KIND_READ) begin
      if (!q6_d && !q7_d) begin
        out_d.read_data = (spinup_d != '0) ? SyncByte : in_q.engine_latch;
      end else if (q6_d && !q7_d) begin
        out_d.read_data = in_q.write_protected ? WpBit : '0;
        if (iwm_en_q) begin
          out_d.read_data = out_d.read_data | (motor_d ? MotorBit : '0)
                            | (mode_q & ModeMask);
        end
      end
    end else if (access && q6_d && q7_d) begin
      if (iwm_en_q && !motor_d) begin
        mode_d = in_q.write_value;
      end else begin
        out_d.latch_load = 1'b1;
        out_d.latch_byte = in_q.write_value;
      end
    end

    out_d.head_position   = head_rsp.pos;
    out_d.head_event      = head_rsp.ev;
    out_d.motor_running   = motor_d;
    out_d.selected_drive  = drive_d;
    out_d.shift_load_mode = q6_d;
    out_d.write_mode      = q7_d;
  end

  // State update and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      motor_q     <= 1'b0;
      spindown_q  <= '0;
      spinup_q    <= '0;
      drive_q     <= 1'b0;
      q6_q        <= 1'b0;
      q7_q        <= 1'b0;
      mode_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_free) begin
        out_valid_q <= in_valid_q;
      end
      if (process) begin
        motor_q    <= motor_d;
        spindown_q <= spindown_d;
        spinup_q   <= spinup_d;
        drive_q    <= drive_d;
        q6_q       <= q6_d;
        q7_q       <= q7_d;
        mode_q     <= mode_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (process) begin
      out_q <= out_d;
    end
  end

endmodule

/* hw/rtl/fssc_checker.sv */
// Port-level checks on the result stream of the floppy soft-switch controller.
// Depends on fssc_pkg; bound to floppy_stepper_motor_switch_ctrl below.
module fssc_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [fssc_pkg::OutDataW-1:0] m_axis_tdata
);
  import fssc_pkg::*;

  out_item_t res;
  assign res = out_item_t'(m_axis_tdata);

  // A stalled result holds its data
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // Motor events agree with the reported motor flag
  a_motor_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (res.motor_event == MEV_ON || res.motor_event == MEV_ON_ENGAGE)
    |-> res.motor_running)
    else $error("motor-on result without running motor");

  a_motor_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && res.motor_event == MEV_DISENGAGE |-> !res.motor_running)
    else $error("disengage result with running motor");

  // One switch per access: a head move carries no motor or drive event
  a_one_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && res.head_event != HEV_NONE
    |-> res.motor_event == MEV_NONE && !res.drive_select_event)
    else $error("head move together with another event");

  // Latch byte is zero unless a load is reported
  a_latch_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !res.latch_load |-> res.latch_byte == '0)
    else $error("latch byte without load");

endmodule

bind floppy_stepper_motor_switch_ctrl fssc_checker u_fssc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

/* dv/floppy_stepper_motor_switch_ctrl_test.sv */
// Self-checking testbench for the floppy soft-switch controller.
// Drives requests and register writes, predicts every result in a local copy of
// the switch logic and compares it. Depends on fssc_pkg and the controller RTL.
`timescale 1ns / 100ps

module floppy_stepper_motor_switch_ctrl_test;
  import fssc_pkg::*;

  // Register index of the mode/status enable (last entry of the register map)
  localparam cfg_idx_e CfgStatusEnable = CFG_IWM_EN;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [InDataW-1:0]   s_axis_tdata  = '0;
  logic [1:0]           s_axis_tuser  = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OutDataW-1:0]  m_axis_tdata;
  logic                 cfg_valid_i   = 1'b0;
  logic                 cfg_ready_o;
  logic [CfgIndexW-1:0] cfg_index_i   = '0;
  logic [CfgDataW-1:0]  cfg_data_i    = '0;

  floppy_stepper_motor_switch_ctrl i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  // Shared run state
  out_item_t   pending_results[$];
  int unsigned mismatches = 0;
  logic        idle_en    = 1'b1;

  // Predicted controller state
  logic [3:0]        magnets;
  logic [PhaseW-1:0] prev_phase;
  logic [PosW-1:0]   head_pos;
  logic              motor_on;
  logic [TimerW-1:0] spindown_cnt;
  logic [TimerW-1:0] spinup_cnt;
  logic              drive_num;
  logic              q6;
  logic              q7;
  logic [ByteW-1:0]  mode_reg;

  // Predicted register contents
  logic [TimerW-1:0] spindown_len = SpindownReset;
  logic [TimerW-1:0] spinup_len   = SpinupReset;
  logic [PosW-1:0]   max_pos      = MaxQtReset;
  logic              status_en    = 1'b0;

  initial begin
    magnets      = '0;
    prev_phase   = '0;
    head_pos     = '0;
    motor_on     = 1'b0;
    spindown_cnt = '0;
    spinup_cnt   = '0;
    drive_num    = 1'b0;
    q6           = 1'b0;
    q7           = 1'b0;
    mode_reg     = '0;
  end

  // Quarter-track move for energizing ph after prev_phase
  function automatic int quarter_step(logic [PhaseW-1:0] lp, logic [PhaseW-1:0] ph);
    logic [PhaseW-1:0] diff;
    diff = ph - lp;
    case (diff)
      2'd0:    return 0;
      2'd1:    return 2;
      2'd3:    return -2;
      default: return (lp < 2) ? 4 : -4;  // opposite magnet: direction depends on origin
    endcase
  endfunction

  // Magnet access: update mask and head, report step or bump
  function automatic head_event_e move_head(logic [PhaseW-1:0] ph, logic on);
    int          delta;
    int          target;
    head_event_e ev;
    delta = 0;
    ev    = HEV_NONE;
    if (on) begin
      magnets    = magnets | (4'b1 << ph);
      delta      = quarter_step(prev_phase, ph);
      prev_phase = ph;
    end else begin
      magnets = magnets & ~(4'b1 << ph);
    end
    target = int'(head_pos) + delta;
    if (delta != 0)
      ev = (target < 0 || target > int'(max_pos)) ? HEV_BUMP : HEV_STEP;
    if (target < 0) target = 0;
    if (target > int'(max_pos)) target = int'(max_pos);
    head_pos = target[PosW-1:0];
    return ev;
  endfunction

  // Expected result of one request; advances the predicted state
  function automatic out_item_t switch_access_result(kind_e k, in_item_t it);
    out_item_t r;
    logic      cold;
    sw_grp_e   grp;
    r   = '0;
    grp = sw_grp_e'(it.switch_offset[3:1]);
    if (k == KIND_READ || k == KIND_WRITE) begin
      case (grp)
        GRP_PHASE0, GRP_PHASE1, GRP_PHASE2, GRP_PHASE3: begin
          r.head_event = move_head(grp[1:0], it.switch_offset[0]);
        end
        GRP_MOTOR: begin
          if (it.switch_offset[0]) begin
            cold         = !motor_on;
            spindown_cnt = '0;
            motor_on     = 1'b1;
            if (cold) spinup_cnt = spinup_len;
            r.motor_event = cold ? MEV_ON_ENGAGE : MEV_ON;
          end else begin
            // Only a running motor with no pending spindown rearms the timer
            if (motor_on && spindown_cnt == 0)
              spindown_cnt = (spindown_len != 0) ? spindown_len : 24'd1;
            r.motor_event = MEV_OFF;
          end
        end
        GRP_DRIVE: begin
          drive_num              = it.switch_offset[0];
          r.drive_select_event   = 1'b1;
        end
        GRP_Q6:  q6 = it.switch_offset[0];
        default: q7 = it.switch_offset[0];
      endcase

      if (k == KIND_READ) begin
        if (!q6 && !q7) begin
          r.read_data = (spinup_cnt != 0) ? SyncByte : it.engine_latch;
        end else if (q6 && !q7) begin
          r.read_data = it.write_protected ? WpBit : 8'h00;
          if (status_en)
            r.read_data = r.read_data | (motor_on ? MotorBit : 8'h00) | (mode_reg & ModeMask);
        end
      end else if (q6 && q7) begin
        if (status_en && !motor_on) begin
          mode_reg = it.write_value;
        end else begin
          r.latch_load = 1'b1;
          r.latch_byte = it.write_value;
        end
      end
    end else if (k == KIND_TICK) begin
      // Both timers saturate at zero
      if (spinup_cnt != 0) begin
        if (TimerW'(it.tick_cycles) >= spinup_cnt) spinup_cnt = '0;
        else spinup_cnt = spinup_cnt - TimerW'(it.tick_cycles);
      end
      if (spindown_cnt != 0) begin
        if (TimerW'(it.tick_cycles) >= spindown_cnt) begin
          spindown_cnt  = '0;
          motor_on      = 1'b0;
          r.motor_event = MEV_DISENGAGE;
        end else begin
          spindown_cnt = spindown_cnt - TimerW'(it.tick_cycles);
        end
      end
    end
    r.head_position   = head_pos;
    r.motor_running   = motor_on;
    r.selected_drive  = drive_num;
    r.shift_load_mode = q6;
    r.write_mode      = q7;
    return r;
  endfunction

  // Switch offset from its pair and the off/on bit
  function automatic logic [3:0] sw(sw_grp_e grp, logic on);
    return {grp, on};
  endfunction

  // Request item with random data fields
  function automatic in_item_t item_of(logic [3:0] offset, logic [TickW-1:0] cyc);
    in_item_t it;
    it                 = '0;
    it.switch_offset   = offset;
    it.write_value     = ByteW'($urandom_range(0, 255));
    it.tick_cycles     = cyc;
    it.engine_latch    = ByteW'($urandom_range(0, 255));
    it.write_protected = 1'($urandom_range(0, 1));
    return it;
  endfunction

  // Send one request after a random gap; record its expected result on acceptance
  task automatic send_request(kind_e k, in_item_t item);
    int unsigned gap;
    gap = idle_en ? $urandom_range(0, 6) : 0;
    @(negedge clk_i);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= item;
    s_axis_tuser  <= k;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_results.push_back(switch_access_result(k, item));
  endtask

  // Stop sending and wait until every result is back
  task automatic drain;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Register write; block must be idle
  task automatic write_register(cfg_idx_e idx, logic [CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_SPINDOWN:    spindown_len = val;
      CFG_SPINUP:      spinup_len   = val;
      CFG_MAX_QT:      max_pos      = val[PosW-1:0];
      CfgStatusEnable: status_en    = val[0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic configure(logic [TimerW-1:0] down, logic [TimerW-1:0] up,
                           logic [PosW-1:0] maxq, logic en);
    write_register(CFG_SPINDOWN, down);
    write_register(CFG_SPINUP, up);
    write_register(CFG_MAX_QT, CfgDataW'(maxq));
    write_register(CfgStatusEnable, CfgDataW'(en));
  endtask

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%t %s: expected %0h, got %0h", $realtime, name, want, got);
    end
  endtask

  // Result side: random stall per result, then compare with the oldest expectation
  initial begin : result_monitor
    int unsigned stall;
    out_item_t   got;
    out_item_t   want;
    forever begin
      stall = idle_en ? $urandom_range(0, 6) : 0;
      @(negedge clk_i);
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready));
      got = m_axis_tdata;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("%t result with no pending request: %h", $realtime, got);
      end else begin
        want = pending_results.pop_front();
        check_field("read_data", want.read_data, got.read_data);
        check_field("latch_load", 8'(want.latch_load), 8'(got.latch_load));
        check_field("latch_byte", want.latch_byte, got.latch_byte);
        check_field("head_position", want.head_position, got.head_position);
        check_field("head_event", 8'(want.head_event), 8'(got.head_event));
        check_field("motor_running", 8'(want.motor_running), 8'(got.motor_running));
        check_field("motor_event", 8'(want.motor_event), 8'(got.motor_event));
        check_field("selected_drive", 8'(want.selected_drive), 8'(got.selected_drive));
        check_field("drive_select_event", 8'(want.drive_select_event),
                    8'(got.drive_select_event));
        check_field("shift_load_mode", 8'(want.shift_load_mode), 8'(got.shift_load_mode));
        check_field("write_mode", 8'(want.write_mode), 8'(got.write_mode));
        check_field("pad", 8'(want.pad), 8'(got.pad));
      end
    end
  end

  // Stepping in both directions, bumps at zero, phase-off, clamp to a lowered max
  task automatic test_head_stepping;
    send_request(KIND_READ,  item_of(sw(GRP_PHASE1, 1'b1), '0));
    send_request(KIND_READ,  item_of(sw(GRP_PHASE2, 1'b1), '0));
    send_request(KIND_WRITE, item_of(sw(GRP_PHASE0, 1'b1), '0));
    send_request(KIND_READ,  item_of(sw(GRP_PHASE3, 1'b1), '0));
    send_request(KIND_WRITE, item_of(sw(GRP_PHASE1, 1'b1), '0));
    send_request(KIND_WRITE, item_of(sw(GRP_PHASE1, 1'b0), '0));
    send_request(KIND_READ,  item_of(sw(GRP_PHASE3, 1'b1), '0));
    drain();
    write_register(CFG_MAX_QT, CfgDataW'(1));
    // head is beyond the new max: any phase access clamps it
    send_request(KIND_READ,  item_of(sw(GRP_PHASE0, 1'b0), '0));
    send_request(KIND_READ,  item_of(sw(GRP_PHASE0, 1'b1), '0));
  endtask

  // Spin-up window, zero spindown register, repeated off, on during spindown
  task automatic test_motor_timers;
    drain();
    write_register(CFG_SPINDOWN, '0);
    write_register(CFG_SPINUP, CfgDataW'(100));
    send_request(KIND_READ,  item_of(sw(GRP_MOTOR, 1'b1), '0));
    send_request(KIND_TICK,  item_of(sw(GRP_MOTOR, 1'b1), '0));
    send_request(KIND_READ,  item_of(sw(GRP_Q6, 1'b0), '0));
    send_request(KIND_TICK,  item_of(4'hF, 16'hFFFF));
    send_request(KIND_READ,  item_of(sw(GRP_Q7, 1'b0), '0));
    send_request(KIND_WRITE, item_of(sw(GRP_MOTOR, 1'b1), '0));
    send_request(KIND_READ,  item_of(sw(GRP_MOTOR, 1'b0), '0));
    send_request(KIND_WRITE, item_of(sw(GRP_MOTOR, 1'b0), '0));
    send_request(KIND_READ,  item_of(sw(GRP_MOTOR, 1'b1), '0));
    send_request(KIND_WRITE, item_of(sw(GRP_MOTOR, 1'b0), '0));
    send_request(KIND_TICK,  item_of(4'h0, 16'd1));
  endtask

  // Mode register load, status read, write latch load, drive select
  task automatic test_read_write_paths;
    in_item_t it;
    drain();
    write_register(CfgStatusEnable, CfgDataW'(1));
    send_request(KIND_WRITE, item_of(sw(GRP_Q7, 1'b1), '0));
    it             = item_of(sw(GRP_Q6, 1'b1), '0);
    it.write_value = 8'hFF;
    send_request(KIND_WRITE, it);
    it                 = item_of(sw(GRP_Q7, 1'b0), '0);
    it.write_protected = 1'b1;
    it.engine_latch    = 8'hFF;
    send_request(KIND_READ, it);
    send_request(KIND_READ,  item_of(sw(GRP_DRIVE, 1'b1), '0));
    send_request(KIND_WRITE, item_of(sw(GRP_MOTOR, 1'b1), '0));
    it             = item_of(sw(GRP_Q7, 1'b1), '0);
    it.write_value = 8'h00;
    send_request(KIND_WRITE, it);
    send_request(KIND_READ,  item_of(sw(GRP_DRIVE, 1'b0), '0));
  endtask

  // Undefined kind changes nothing
  task automatic test_undefined_kind;
    send_request(KIND_NONE, item_of(sw(GRP_MOTOR, 1'b0), 16'hFFFF));
    send_request(KIND_NONE, item_of(sw(GRP_PHASE2, 1'b1), '0));
  endtask

  // Random traffic over several register settings, with seek bursts
  task automatic test_random_traffic;
    int unsigned       sent;
    int unsigned       pick;
    int unsigned       burst;
    logic              up_dir;
    logic [PhaseW-1:0] ph;
    logic [TickW-1:0]  cyc;
    kind_e             k;
    for (int p = 0; p < 5; p++) begin
      drain();
      case (p)
        0:       configure(24'd1, 24'd0, 8'd1, 1'b1);
        1:       configure(24'hFFFFFF, 24'hFFFFFF, 8'd255, 1'b0);
        default: configure(TimerW'($urandom_range(1, 200000)), TimerW'($urandom_range(0, 100000)),
                           PosW'($urandom_range(1, 255)), 1'($urandom_range(0, 1)));
      endcase
      sent = 0;
      while (sent < 90) begin
        if (sent % 30 == 0) idle_en = ($urandom_range(0, 3) != 0);
        pick = $urandom_range(0, 99);
        if (pick < 15) begin
          // seek: energize neighboring magnets in one direction, now and then the opposite magnet
          burst  = $urandom_range(3, 8);
          up_dir = 1'($urandom_range(0, 1));
          for (int j = 0; j < burst; j++) begin
            ph = prev_phase + (up_dir ? 2'd1 : 2'd3);
            if ($urandom_range(0, 4) == 0) ph = prev_phase + 2'd2;
            k  = $urandom_range(0, 1) ? KIND_WRITE : KIND_READ;
            send_request(k, item_of(sw(sw_grp_e'({1'b0, ph}), 1'b1), '0));
          end
          sent += burst;
        end else if (pick < 40) begin
          cyc = $urandom_range(0, 1) ? TickW'($urandom_range(0, 65535))
                                     : TickW'($urandom_range(0, 200));
          send_request(KIND_TICK, item_of(4'($urandom_range(0, 15)), cyc));
          sent++;
        end else if (pick < 43) begin
          send_request(KIND_NONE, item_of(4'($urandom_range(0, 15)),
                                          TickW'($urandom_range(0, 65535))));
          sent++;
        end else begin
          k = $urandom_range(0, 1) ? KIND_WRITE : KIND_READ;
          send_request(k, item_of(4'($urandom_range(0, 15)), TickW'($urandom_range(0, 65535))));
          sent++;
        end
      end
    end
    idle_en = 1'b1;
  endtask

  // Main sequence
  initial begin
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_head_stepping();
    test_motor_timers();
    test_read_write_paths();
    test_undefined_kind();
    test_random_traffic();
    drain();
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("floppy_stepper_motor_switch_ctrl: match");
    end else begin
      $display("floppy_stepper_motor_switch_ctrl: mismatch");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #500us;
    $display("floppy_stepper_motor_switch_ctrl: mismatch");
    $finish;
  end

endmodule
